@@ rtl/core/tcf_pkg.sv @@
// Shared types, widths and constants for the tilt complementary filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tcf_pkg;

   localparam int unsigned CORDIC_STEPS_DEF = 14;
   localparam int unsigned ATAN_LEN         = 20;

   localparam int unsigned XY_W     = 28;
   localparam int unsigned Z_W      = 34;
   localparam int unsigned ANG_W    = 16;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned WEIGHT_W = 17;
   localparam int unsigned PERIOD_W = 16;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd32768;
   localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd262;

   localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

   typedef struct packed {
      logic                   valid;
      logic                   zero;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } tcf_cordic_type;

   // arctan(2^-idx) in Q2.30, truncated
   function automatic logic signed [Z_W-1:0] tcf_atan(input int unsigned idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         0:       val = 34'sd843314856;
         1:       val = 34'sd497837829;
         2:       val = 34'sd263043836;
         3:       val = 34'sd133525158;
         4:       val = 34'sd67021686;
         5:       val = 34'sd33543515;
         6:       val = 34'sd16775850;
         7:       val = 34'sd8388437;
         8:       val = 34'sd4194282;
         9:       val = 34'sd2097149;
         10:      val = 34'sd1048575;
         11:      val = 34'sd524287;
         12:      val = 34'sd262143;
         13:      val = 34'sd131071;
         14:      val = 34'sd65535;
         15:      val = 34'sd32767;
         16:      val = 34'sd16383;
         17:      val = 34'sd8191;
         18:      val = 34'sd4095;
         19:      val = 34'sd2047;
         default: val = 34'sd0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/core/tcf_cordic_cell.sv @@
// One vectoring CORDIC iteration, registered; hands its beat to the next cell.
// Depends on tcf_pkg.
`timescale 1ns / 1ps

module tcf_cordic_cell
   import tcf_pkg::*;
#(
   parameter int unsigned SHIFT = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  tcf_cordic_type prev_cell,
   output tcf_cordic_type next_cell
);

   localparam logic signed [Z_W-1:0] ATAN_STEP = tcf_atan(SHIFT);

   tcf_cordic_type         stage_ff, stage_in;
   logic signed [XY_W-1:0] dx, dy;

   always_comb begin
      dx       = prev_cell.y >>> SHIFT;
      dy       = prev_cell.x >>> SHIFT;
      stage_in = prev_cell;
      if (prev_cell.y > 0) begin
         stage_in.x = prev_cell.x + dx;
         stage_in.y = prev_cell.y - dy;
         stage_in.z = prev_cell.z + ATAN_STEP;
      end else begin
         stage_in.x = prev_cell.x - dx;
         stage_in.y = prev_cell.y + dy;
         stage_in.z = prev_cell.z - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign next_cell = stage_ff;

endmodule

@@ rtl/core/tcf_cordic.sv @@
// atan2(y, -z) of the accelerometer: quadrant pre-rotation, a row of CORDIC
// cells, then rounding to Q3.12. Depends on tcf_pkg and tcf_cordic_cell.
`timescale 1ns / 1ps

module tcf_cordic
   import tcf_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SAMPLE_W-1:0] accel_y,
   input  logic signed [SAMPLE_W-1:0] accel_z,
   output logic                       acc_valid,
   output logic signed [ANG_W-1:0]    acc_angle
);

   localparam logic signed [Z_W-1:0] Z_ROUND = 34'sd131072;

   tcf_cordic_type         head_ff, head_in;
   tcf_cordic_type         chain [CORDIC_STEPS+1];
   logic signed [XY_W-1:0] ay_ext, az_ext, x_raw, y_raw;
   logic signed [Z_W-1:0]  z_round;
   logic                   acc_valid_ff;
   logic signed [ANG_W-1:0] acc_ff, acc_in;

   always_comb begin
      ay_ext        = {{(XY_W-SAMPLE_W){accel_y[SAMPLE_W-1]}}, accel_y};
      az_ext        = {{(XY_W-SAMPLE_W){accel_z[SAMPLE_W-1]}}, accel_z};
      x_raw         = -(az_ext <<< 8);
      y_raw         = ay_ext <<< 8;
      head_in.valid = start;
      head_in.zero  = (accel_y == '0) && (accel_z == '0);
      head_in.x     = x_raw;
      head_in.y     = y_raw;
      head_in.z     = '0;
      if (x_raw < 0) begin
         if (y_raw >= 0) begin
            head_in.x = y_raw;
            head_in.y = -x_raw;
            head_in.z = HALF_PI_Q30;
         end else begin
            head_in.x = -y_raw;
            head_in.y = x_raw;
            head_in.z = -HALF_PI_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cells
      tcf_cordic_cell #(
         .SHIFT (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_cell (chain[g]),
         .next_cell (chain[g+1])
      );
   end

   always_comb begin
      z_round = chain[CORDIC_STEPS].z + Z_ROUND;
      acc_in  = chain[CORDIC_STEPS].zero ? '0 : z_round[Z_W-1:Z_W-ANG_W];
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (reset) begin
         acc_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= chain[CORDIC_STEPS].valid;
      end
   end

   assign acc_valid = acc_valid_ff;
   assign acc_angle = acc_ff;

endmodule

@@ rtl/core/tcf_fusion.sv @@
// Complementary blend of gyro prediction and accelerometer angle; holds the
// kept angle. Pipelined multiply/add stages, then rounding. Depends on tcf_pkg.
`timescale 1ns / 1ps

module tcf_fusion
   import tcf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       acc_valid,
   input  logic signed [ANG_W-1:0]    acc_angle,
   input  logic signed [SAMPLE_W-1:0] gyro_rate_x,
   input  logic [WEIGHT_W-1:0]        blend_weight,
   input  logic [PERIOD_W-1:0]        sample_period,
   input  logic                       slot_free,
   output logic                       res_fire,
   output logic signed [ANG_W-1:0]    res_angle
);

   localparam logic signed [55:0] NUM_ROUND = 56'sh80000000;

   logic [WEIGHT_W-1:0]     alpha, beta;
   logic                    s1_valid_ff, s2_valid_ff;
   logic signed [32:0]      gd_ff, gd_in;
   logic signed [33:0]      ao_ff, ao_in, bc_ff, bc_in;
   logic signed [50:0]      agd_ff, agd_in;
   logic signed [34:0]      sum_ff, sum_in;
   logic signed [55:0]      num;
   logic signed [23:0]      rnd;
   logic signed [ANG_W-1:0] angle_ff, sat;

   always_comb begin
      alpha  = blend_weight[WEIGHT_W-1] ? WEIGHT_ONE : blend_weight;
      beta   = WEIGHT_ONE - alpha;
      gd_in  = 33'(gyro_rate_x) * 33'($signed({1'b0, sample_period}));
      ao_in  = 34'($signed({1'b0, alpha})) * 34'(angle_ff);
      bc_in  = 34'($signed({1'b0, beta})) * 34'(acc_angle);
      agd_in = 51'(gd_ff) * 51'($signed({1'b0, alpha}));
      sum_in = 35'(ao_ff) + 35'(bc_ff);
      num    = (56'(sum_ff) <<< 16) + (56'(agd_ff) <<< 2) + NUM_ROUND;
      rnd    = num[55:32];
      if (rnd > 24'sd32767) begin
         sat = 16'sh7FFF;
      end else if (rnd < -24'sd32768) begin
         sat = 16'sh8000;
      end else begin
         sat = rnd[ANG_W-1:0];
      end
   end

   assign res_fire  = s2_valid_ff && slot_free;
   assign res_angle = sat;

   always_ff @(posedge clock) begin
      if (acc_valid) begin
         gd_ff <= gd_in;
         ao_ff <= ao_in;
         bc_ff <= bc_in;
      end
      if (s1_valid_ff) begin
         agd_ff <= agd_in;
         sum_ff <= sum_in;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         angle_ff    <= '0;
      end else begin
         s1_valid_ff <= acc_valid;
         if (s1_valid_ff) begin
            s2_valid_ff <= 1'b1;
         end else if (res_fire) begin
            s2_valid_ff <= 1'b0;
         end
         if (res_fire) begin
            angle_ff <= sat;
         end
      end
   end

endmodule

@@ rtl/core/tilt_complementary_filter.sv @@
// Top level of the tilt complementary filter: handshakes, register port,
// output register. Depends on tcf_pkg, tcf_cordic and tcf_fusion.
`timescale 1ns / 1ps

// One IMU sample per beat in, one fused Q3.12 tilt angle per beat out. A sample
// passes, in order, through the pre-rotation stage (loaded at the accepting
// edge), one register per cell of the CORDIC row, one rounding stage, two fusion
// stages and the output register, which loads only when empty or not stalled.
// The kept angle of one sample feeds the next, so req_stall stays high while a
// sample is in flight; the next sample is taken in the cycle after the result
// loads at the earliest. A finished result may wait in the output register while
// the next sample is taken. Registers: blend_weight at 0x0, sample_period at 0x4.
module tilt_complementary_filter
   import tcf_pkg::*;
#(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   input  logic signed [SAMPLE_W-1:0] req_gyro_rate_x,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [ANG_W-1:0]    rsp_tilt_angle,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic {
      REG_BLEND_WEIGHT  = 1'b0,
      REG_SAMPLE_PERIOD = 1'b1
   } csr_reg_type;

   logic                       busy_ff;
   logic signed [SAMPLE_W-1:0] gyro_ff;
   logic [WEIGHT_W-1:0]        blend_ff;
   logic [PERIOD_W-1:0]        period_ff;
   logic                       rsp_valid_ff;
   logic signed [ANG_W-1:0]    rsp_angle_ff;
   logic                       req_accept, csr_write, slot_free, res_fire;
   logic                       acc_valid;
   logic signed [ANG_W-1:0]    acc_angle, res_angle;
   csr_reg_type                csr_reg;

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[2]);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (csr_reg)
         REG_BLEND_WEIGHT:  csr_prdata = {{(32-WEIGHT_W){1'b0}}, blend_ff};
         REG_SAMPLE_PERIOD: csr_prdata = {{(32-PERIOD_W){1'b0}}, period_ff};
         default:           csr_prdata = '0;
      endcase
   end

   tcf_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .accel_y   (req_accel_y),
      .accel_z   (req_accel_z),
      .acc_valid (acc_valid),
      .acc_angle (acc_angle)
   );

   tcf_fusion u_fusion (
      .clock         (clock),
      .reset         (reset),
      .acc_valid     (acc_valid),
      .acc_angle     (acc_angle),
      .gyro_rate_x   (gyro_ff),
      .blend_weight  (blend_ff),
      .sample_period (period_ff),
      .slot_free     (slot_free),
      .res_fire      (res_fire),
      .res_angle     (res_angle)
   );

   always_ff @(posedge clock) begin
      if (req_accept) begin
         gyro_ff <= req_gyro_rate_x;
      end
      if (res_fire) begin
         rsp_angle_ff <= res_angle;
      end
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         blend_ff     <= WEIGHT_RST;
         period_ff    <= PERIOD_RST;
      end else begin
         if (req_accept) begin
            busy_ff <= 1'b1;
         end else if (res_fire) begin
            busy_ff <= 1'b0;
         end
         if (res_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_reg)
               REG_BLEND_WEIGHT:  blend_ff  <= csr_pwdata[WEIGHT_W-1:0];
               REG_SAMPLE_PERIOD: period_ff <= csr_pwdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tilt_angle = rsp_angle_ff;

`ifndef NO_ASSERTIONS
   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy_ff)
      else $error("accepted beat did not mark the block busy");

   a_fire_needs_busy: assert property (@(posedge clock) disable iff (reset)
      res_fire |-> busy_ff)
      else $error("result produced with no sample in flight");

   a_fire_loads_output: assert property (@(posedge clock) disable iff (reset)
      res_fire |=> (rsp_valid_ff && !busy_ff))
      else $error("result not registered or block stayed busy");
`endif

endmodule
